/* sv/srep_pkg.sv */
package srep_pkg;

    localparam int DEF_ELEM_WIDTH  = 16;
    localparam int DEF_MAX_PATTERN = 4;

    localparam int WORD_W    = 64;
    localparam int LEN_W     = 3;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORDS      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_WORDS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_LENGTH = 3'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_REPL,
        ST_FLUSH,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic valid;
        logic last;
        logic done;
    } t_push;

endpackage

/* sv/srep_cfg.sv */
module srep_cfg #(
    parameter int ELEM_WIDTH  = srep_pkg::DEF_ELEM_WIDTH,
    parameter int MAX_PATTERN = srep_pkg::DEF_MAX_PATTERN,
    parameter int CNT_W       = $clog2(MAX_PATTERN + 1)
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_wr,
    input  logic [srep_pkg::CFG_IDX_W-1:0]            i_index,
    input  logic [srep_pkg::WORD_W-1:0]               i_data,
    output logic [MAX_PATTERN-1:0][ELEM_WIDTH-1:0]    o_pat_slots,
    output logic [MAX_PATTERN-1:0][ELEM_WIDTH-1:0]    o_rep_slots,
    output logic [CNT_W-1:0]                          o_plen,
    output logic [CNT_W-1:0]                          o_rlen
);

    localparam int WORD_W = srep_pkg::WORD_W;
    localparam int LEN_W  = srep_pkg::LEN_W;

    logic [WORD_W-1:0] r_pat_words;
    logic [LEN_W-1:0]  r_pat_len;
    logic [WORD_W-1:0] r_rep_words;
    logic [LEN_W-1:0]  r_rep_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_words <= '0;
            r_pat_len   <= LEN_W'(1);
            r_rep_words <= '0;
            r_rep_len   <= '0;
        end else if (i_wr) begin
            case (i_index)
                srep_pkg::CFG_PATTERN_WORDS:      r_pat_words <= i_data;
                srep_pkg::CFG_PATTERN_LENGTH:     r_pat_len   <= i_data[LEN_W-1:0];
                srep_pkg::CFG_REPLACEMENT_WORDS:  r_rep_words <= i_data;
                srep_pkg::CFG_REPLACEMENT_LENGTH: r_rep_len   <= i_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Lengths saturate at the buffer depth; a pattern length of zero acts as one.
    always_comb begin
        if (r_pat_len == '0) begin
            o_plen = CNT_W'(1);
        end else if ({1'b0, r_pat_len} > (LEN_W + 1)'(MAX_PATTERN)) begin
            o_plen = CNT_W'(MAX_PATTERN);
        end else begin
            o_plen = CNT_W'(r_pat_len);
        end
        if ({1'b0, r_rep_len} > (LEN_W + 1)'(MAX_PATTERN)) begin
            o_rlen = CNT_W'(MAX_PATTERN);
        end else begin
            o_rlen = CNT_W'(r_rep_len);
        end
    end

    // Slots that run past the 64-bit word are cut off and read as zero beyond it.
    for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_slot
        if ((g + 1) * ELEM_WIDTH <= WORD_W) begin : g_full
            assign o_pat_slots[g] = r_pat_words[g*ELEM_WIDTH +: ELEM_WIDTH];
            assign o_rep_slots[g] = r_rep_words[g*ELEM_WIDTH +: ELEM_WIDTH];
        end else if (g * ELEM_WIDTH < WORD_W) begin : g_part
            assign o_pat_slots[g] = ELEM_WIDTH'(r_pat_words[WORD_W-1:g*ELEM_WIDTH]);
            assign o_rep_slots[g] = ELEM_WIDTH'(r_rep_words[WORD_W-1:g*ELEM_WIDTH]);
        end else begin : g_none
            assign o_pat_slots[g] = '0;
            assign o_rep_slots[g] = '0;
        end
    end

endmodule

/* sv/srep_match.sv */
module srep_match #(
    parameter int ELEM_WIDTH  = srep_pkg::DEF_ELEM_WIDTH,
    parameter int MAX_PATTERN = srep_pkg::DEF_MAX_PATTERN,
    parameter int CNT_W       = $clog2(MAX_PATTERN + 1)
) (
    input  logic [MAX_PATTERN-1:0][ELEM_WIDTH-1:0] i_buf,
    input  logic [CNT_W-1:0]                       i_cnt,
    input  logic [MAX_PATTERN-1:0][ELEM_WIDTH-1:0] i_pat_slots,
    input  logic [CNT_W-1:0]                       i_plen,
    output logic                                   o_match
);

    // True when the held window is a prefix of the pattern.
    always_comb begin
        logic ok;
        ok = (i_cnt <= i_plen);
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if ((CNT_W'(i) < i_cnt) && (i_buf[i] != i_pat_slots[i])) begin
                ok = 1'b0;
            end
        end
        o_match = ok;
    end

endmodule

/* sv/srep_ctrl.sv */
module srep_ctrl #(
    parameter int ELEM_WIDTH  = srep_pkg::DEF_ELEM_WIDTH,
    parameter int MAX_PATTERN = srep_pkg::DEF_MAX_PATTERN,
    parameter int CNT_W       = $clog2(MAX_PATTERN + 1)
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic [ELEM_WIDTH-1:0]                  i_element,
    input  logic                                   i_eos,
    input  logic [CNT_W-1:0]                       i_plen,
    input  logic [CNT_W-1:0]                       i_rlen,
    input  logic [MAX_PATTERN-1:0][ELEM_WIDTH-1:0] i_rep_slots,
    input  logic                                   i_match,
    output logic [MAX_PATTERN-1:0][ELEM_WIDTH-1:0] o_buf,
    output logic [CNT_W-1:0]                       o_cnt,
    input  logic                                   i_out_free,
    output srep_pkg::t_push                        o_push,
    output logic [ELEM_WIDTH-1:0]                  o_push_data
);

    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    srep_pkg::t_state r_state, n_state;

    logic [MAX_PATTERN-1:0][ELEM_WIDTH-1:0] r_buf;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [CNT_W-1:0]      r_rep, n_rep;
    logic                  r_eos, n_eos;
    logic                  r_pend_valid, n_pend_valid;
    logic [ELEM_WIDTH-1:0] r_pend_data;

    logic                  w_accept;
    logic                  w_emit;
    logic [ELEM_WIDTH-1:0] w_emit_data;
    logic                  w_shift;
    logic                  w_rep_step;
    logic                  w_last_push;
    logic                  w_found;

    assign w_found  = (r_cnt == '0) || i_match;
    assign w_accept = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            srep_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = srep_pkg::ST_SEARCH;
            end
            srep_pkg::ST_SEARCH: begin
                if (w_found) begin
                    if (r_cnt == i_plen) n_state = srep_pkg::ST_REPL;
                    else if (r_eos)      n_state = srep_pkg::ST_FLUSH;
                    else                 n_state = srep_pkg::ST_FINISH;
                end
            end
            srep_pkg::ST_REPL: begin
                if (r_rep == i_rlen) begin
                    n_state = r_eos ? srep_pkg::ST_FLUSH : srep_pkg::ST_FINISH;
                end
            end
            srep_pkg::ST_FLUSH: begin
                if (r_cnt == '0) n_state = srep_pkg::ST_FINISH;
            end
            srep_pkg::ST_FINISH: begin
                if (!r_pend_valid || i_out_free) n_state = srep_pkg::ST_IDLE;
            end
            default: n_state = srep_pkg::ST_IDLE;
        endcase
    end

    // Every produced element goes to a one-deep pending slot first, so the
    // previous one can be released once it is known not to be the last.
    always_comb begin
        o_in_ready  = 1'b0;
        w_emit      = 1'b0;
        w_emit_data = r_buf[0];
        w_shift     = 1'b0;
        w_rep_step  = 1'b0;
        w_last_push = 1'b0;
        case (r_state)
            srep_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
            end
            srep_pkg::ST_SEARCH: begin
                if (!w_found && i_out_free) begin
                    w_emit  = 1'b1;
                    w_shift = 1'b1;
                end
            end
            srep_pkg::ST_REPL: begin
                if ((r_rep != i_rlen) && i_out_free) begin
                    w_emit      = 1'b1;
                    w_emit_data = i_rep_slots[r_rep[IDX_W-1:0]];
                    w_rep_step  = 1'b1;
                end
            end
            srep_pkg::ST_FLUSH: begin
                if ((r_cnt != '0) && i_out_free) begin
                    w_emit  = 1'b1;
                    w_shift = 1'b1;
                end
            end
            srep_pkg::ST_FINISH: begin
                w_last_push = r_pend_valid && i_out_free;
            end
            default: ;
        endcase
        o_push.valid = (w_emit && r_pend_valid) || w_last_push;
        o_push.last  = w_last_push;
        o_push.done  = w_last_push && r_eos;
        o_push_data  = r_pend_data;
    end

    always_comb begin
        n_cnt        = r_cnt;
        n_rep        = r_rep;
        n_eos        = r_eos;
        n_pend_valid = r_pend_valid;
        if (w_accept) begin
            n_cnt = r_cnt + CNT_W'(1);
            n_rep = '0;
            n_eos = i_eos;
        end else if (w_shift) begin
            n_cnt = r_cnt - CNT_W'(1);
        end else if ((r_state == srep_pkg::ST_SEARCH) && w_found && (r_cnt == i_plen)) begin
            n_cnt = '0;
        end
        if (w_rep_step) n_rep = r_rep + CNT_W'(1);
        if (w_emit) begin
            n_pend_valid = 1'b1;
        end else if (w_last_push) begin
            n_pend_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= srep_pkg::ST_IDLE;
            r_cnt        <= '0;
            r_rep        <= '0;
            r_eos        <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cnt        <= n_cnt;
            r_rep        <= n_rep;
            r_eos        <= n_eos;
            r_pend_valid <= n_pend_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_buf[r_cnt[IDX_W-1:0]] <= i_element;
        end else if (w_shift) begin
            for (int i = 0; i < MAX_PATTERN - 1; i++) begin
                r_buf[i] <= r_buf[i+1];
            end
        end
        if (w_emit) r_pend_data <= w_emit_data;
    end

    assign o_buf = r_buf;
    assign o_cnt = r_cnt;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_PATTERN))
        else $error("held count exceeds buffer depth");

    a_idle_below_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == srep_pkg::ST_IDLE) |-> (r_cnt < CNT_W'(MAX_PATTERN)))
        else $error("buffer full while waiting for input");

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.valid |-> i_out_free)
        else $error("push into an occupied output register");

    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == srep_pkg::ST_IDLE) |-> !r_pend_valid)
        else $error("pending element left behind at end of item");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_in_ready)
        else $error("ready again right after accepting an item");
`endif

endmodule

/* sv/stream_sequence_replacer_core.sv */
// Items are handled one at a time, which the single window compare unit sets: a new element is
// accepted only in the idle state, once the search has released the held elements that can no
// longer start a match (at most MAX_PATTERN), the replacement has been emitted on a match and
// the held elements have been flushed at end of stream; output stalls can hold each step.
// Reset (synchronous, active low) clears the sequencer, the held count and the configuration
// registers to their defaults; the held element buffer is not cleared and needs no sweep.
module stream_sequence_replacer_core #(
    parameter int ELEM_WIDTH  = srep_pkg::DEF_ELEM_WIDTH,
    parameter int MAX_PATTERN = srep_pkg::DEF_MAX_PATTERN
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [((ELEM_WIDTH+7)/8)*8-1:0]    s_axis_tdata,  // element
    input  logic                               s_axis_tlast,  // end_of_stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [((ELEM_WIDTH+7)/8)*8-1:0]    m_axis_tdata,  // out_element
    output logic                               m_axis_tlast,  // run_last
    output logic                               m_axis_tuser,  // stream_done
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [srep_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [srep_pkg::WORD_W-1:0]        i_cfg_data
);

    localparam int TDATA_W = ((ELEM_WIDTH + 7) / 8) * 8;
    localparam int CNT_W   = $clog2(MAX_PATTERN + 1);

    logic [MAX_PATTERN-1:0][ELEM_WIDTH-1:0] w_pat_slots;
    logic [MAX_PATTERN-1:0][ELEM_WIDTH-1:0] w_rep_slots;
    logic [MAX_PATTERN-1:0][ELEM_WIDTH-1:0] w_buf;
    logic [CNT_W-1:0]                       w_plen;
    logic [CNT_W-1:0]                       w_rlen;
    logic [CNT_W-1:0]                       w_cnt;
    logic                                   w_match;
    logic                                   w_out_free;
    srep_pkg::t_push                        w_push;
    logic [ELEM_WIDTH-1:0]                  w_push_data;

    logic                  r_out_valid;
    logic                  r_out_last;
    logic                  r_out_done;
    logic [ELEM_WIDTH-1:0] r_out_data;

    assign o_cfg_ready = 1'b1;

    srep_cfg #(
        .ELEM_WIDTH  (ELEM_WIDTH),
        .MAX_PATTERN (MAX_PATTERN),
        .CNT_W       (CNT_W)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (i_cfg_valid && o_cfg_ready),
        .i_index     (i_cfg_index),
        .i_data      (i_cfg_data),
        .o_pat_slots (w_pat_slots),
        .o_rep_slots (w_rep_slots),
        .o_plen      (w_plen),
        .o_rlen      (w_rlen)
    );

    srep_match #(
        .ELEM_WIDTH  (ELEM_WIDTH),
        .MAX_PATTERN (MAX_PATTERN),
        .CNT_W       (CNT_W)
    ) u_match (
        .i_buf       (w_buf),
        .i_cnt       (w_cnt),
        .i_pat_slots (w_pat_slots),
        .i_plen      (w_plen),
        .o_match     (w_match)
    );

    srep_ctrl #(
        .ELEM_WIDTH  (ELEM_WIDTH),
        .MAX_PATTERN (MAX_PATTERN),
        .CNT_W       (CNT_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_element   (s_axis_tdata[ELEM_WIDTH-1:0]),
        .i_eos       (s_axis_tlast),
        .i_plen      (w_plen),
        .i_rlen      (w_rlen),
        .i_rep_slots (w_rep_slots),
        .i_match     (w_match),
        .o_buf       (w_buf),
        .o_cnt       (w_cnt),
        .i_out_free  (w_out_free),
        .o_push      (w_push),
        .o_push_data (w_push_data)
    );

    // Output register: takes a new element when empty or drained in the same cycle.
    assign w_out_free = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_push.valid) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push.valid) begin
            r_out_data <= w_push_data;
            r_out_last <= w_push.last;
            r_out_done <= w_push.done;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = TDATA_W'(r_out_data);
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_done;

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;

    localparam int EW          = srep_pkg::DEF_ELEM_WIDTH;
    localparam int DW          = ((EW + 7) / 8) * 8;
    localparam int MAXP        = srep_pkg::DEF_MAX_PATTERN;
    localparam int WORD_W      = srep_pkg::WORD_W;
    localparam int LEN_W       = srep_pkg::LEN_W;
    localparam int CFG_IDX_W   = srep_pkg::CFG_IDX_W;
    localparam int SETTLE      = 24;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 26;

    // An index past the register list; the block must ignore writes to it.
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_UNUSED = 3'd6;

    typedef struct packed {
        logic [EW-1:0] elem;
        logic          run_last;
        logic          stream_done;
    } t_beat;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [DW-1:0]        s_axis_tdata;
    logic                 s_axis_tlast;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [DW-1:0]        m_axis_tdata;
    logic                 m_axis_tlast;
    logic                 m_axis_tuser;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [WORD_W-1:0]    i_cfg_data;

    stream_sequence_replacer_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Shadow copy of the configuration and the partial-match state.
    logic [WORD_W-1:0] model_pat_words = '0;
    logic [LEN_W-1:0]  model_pat_len   = 3'd1;
    logic [WORD_W-1:0] model_rep_words = '0;
    logic [LEN_W-1:0]  model_rep_len   = '0;
    logic [EW-1:0]     model_held [0:MAXP-1];
    int                model_held_cnt  = 0;

    t_beat         expected_out [$];
    logic [EW-1:0] alpha [0:2];

    int tx_idle_pct   = 32;
    int rx_idle_pct   = 32;
    int hold_requests = 0;
    int errors        = 0;
    int items_sent    = 0;
    int results_seen  = 0;
    int replacements  = 0;
    int reg_writes    = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #(5_000_000);
        $display("CHECK FAILED");
        $finish;
    end

    function automatic logic [EW-1:0] pat_slot(input logic [WORD_W-1:0] words, input int idx);
        return words[idx*EW +: EW];
    endfunction

    function automatic int eff_pat_len();
        if (model_pat_len == 0) return 1;
        if (model_pat_len > MAXP) return MAXP;
        return int'(model_pat_len);
    endfunction

    // Appends one element to the held run, releases whatever can no longer start
    // a match, substitutes the replacement on a full match and flushes on end of stream.
    function automatic void rewrite_element(input logic [EW-1:0] elem, input logic eos);
        logic [EW-1:0] win [0:MAXP];
        logic [EW-1:0] emitted [$];
        int   plen, rlen, n, s, start, len, i;
        bit   fits;
        t_beat b;
        plen = eff_pat_len();
        rlen = (model_rep_len > MAXP) ? MAXP : int'(model_rep_len);
        for (i = 0; i < model_held_cnt; i++) win[i] = model_held[i];
        win[model_held_cnt] = elem;
        n = model_held_cnt + 1;
        // Walking down leaves the earliest start whose tail is a pattern prefix.
        start = n;
        for (s = n - 1; s >= 0; s--) begin
            len = n - s;
            if (len <= plen) begin
                fits = 1'b1;
                for (i = 0; i < len; i++)
                    if (win[s+i] != pat_slot(model_pat_words, i)) fits = 1'b0;
                if (fits) start = s;
            end
        end
        for (i = 0; i < start; i++) emitted.push_back(win[i]);
        len = n - start;
        if (len == plen) begin
            for (i = 0; i < rlen; i++) emitted.push_back(pat_slot(model_rep_words, i));
            model_held_cnt = 0;
            replacements++;
        end else begin
            for (i = 0; i < len; i++) model_held[i] = win[start+i];
            model_held_cnt = len;
        end
        if (eos) begin
            for (i = 0; i < model_held_cnt; i++) emitted.push_back(model_held[i]);
            model_held_cnt = 0;
        end
        for (i = 0; i < emitted.size(); i++) begin
            b.elem        = emitted[i];
            b.run_last    = (i == emitted.size() - 1);
            b.stream_done = eos && (i == emitted.size() - 1);
            expected_out.push_back(b);
        end
    endfunction

    task automatic send_item(input logic [EW-1:0] elem, input logic eos);
        @(negedge i_clk);
        while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = DW'(elem);
        s_axis_tlast  = eos;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        rewrite_element(elem, eos);
        items_sent++;
    endtask

    // Lets every pending result drain and gives a silent item time to finish.
    task automatic wait_quiet();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (expected_out.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            srep_pkg::CFG_PATTERN_WORDS:      model_pat_words = value;
            srep_pkg::CFG_PATTERN_LENGTH:     model_pat_len   = value[LEN_W-1:0];
            srep_pkg::CFG_REPLACEMENT_WORDS:  model_rep_words = value;
            srep_pkg::CFG_REPLACEMENT_LENGTH: model_rep_len   = value[LEN_W-1:0];
            default: ;
        endcase
        reg_writes++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_replacer(input logic [WORD_W-1:0] pw, input logic [LEN_W-1:0] pl,
                                input logic [WORD_W-1:0] rw, input logic [LEN_W-1:0] rl);
        wait_quiet();
        write_reg(srep_pkg::CFG_PATTERN_WORDS, pw);
        write_reg(srep_pkg::CFG_PATTERN_LENGTH, WORD_W'(pl));
        write_reg(srep_pkg::CFG_REPLACEMENT_WORDS, rw);
        write_reg(srep_pkg::CFG_REPLACEMENT_LENGTH, WORD_W'(rl));
    endtask

    function automatic logic [EW-1:0] pick_elem();
        int r;
        r = $urandom_range(99);
        if (r < 60) return pat_slot(model_pat_words, $urandom_range(eff_pat_len() - 1));
        if (r < 75) return alpha[$urandom_range(2)];
        if (r < 85) return pat_slot(model_rep_words, $urandom_range(MAXP - 1));
        return EW'($urandom);
    endfunction

    task automatic new_random_setting();
        logic [WORD_W-1:0] pw;
        int k, r;
        for (k = 0; k < 3; k++) begin
            r = $urandom_range(9);
            alpha[k] = (r == 0) ? 16'h8000 : (r == 1) ? 16'h7FFF : EW'($urandom);
        end
        pw = {$urandom, $urandom};
        for (k = 0; k < MAXP; k++) pw[k*EW +: EW] = alpha[$urandom_range(2)];
        set_replacer(pw,
                     ($urandom_range(3) == 0) ? LEN_W'($urandom_range(7))
                                              : LEN_W'($urandom_range(1, MAXP)),
                     {$urandom, $urandom}, LEN_W'($urandom_range(7)));
        if ($urandom_range(3) == 0) write_reg(CFG_INDEX_UNUSED, {$urandom, $urandom});
    endtask

    // Defaults: pattern is a single zero with an empty replacement, so zeros vanish.
    task automatic test_reset_defaults();
        send_item(16'h0000, 1'b0);
        send_item(16'h0005, 1'b0);
        send_item(16'h0005, 1'b1);
    endtask

    task automatic test_directed_cases();
        // Oversized lengths saturate to four elements.
        set_replacer({16'hFFFF, 16'h0000, 16'h7FFF, 16'h8000}, 3'd7,
                     {16'h4444, 16'h3333, 16'h2222, 16'h1111}, 3'd4);
        send_item(16'h8000, 1'b0);
        send_item(16'h7FFF, 1'b0);
        send_item(16'h0000, 1'b0);
        send_item(16'hFFFF, 1'b0);
        // A broken match falls back onto the restarted prefix.
        send_item(16'h8000, 1'b0);
        send_item(16'h7FFF, 1'b0);
        send_item(16'h8000, 1'b0);
        send_item(16'h7FFF, 1'b0);
        send_item(16'h0000, 1'b0);
        send_item(16'hFFFF, 1'b0);
        // End of stream flushes a held partial match.
        send_item(16'h8000, 1'b0);
        send_item(16'h7FFF, 1'b1);

        // Repeated leading elements exercise the fallback walk.
        set_replacer({16'h0000, 16'h0007, 16'h0005, 16'h0005}, 3'd3,
                     {$urandom, $urandom}, 3'd7);
        send_item(16'h0005, 1'b0);
        send_item(16'h0005, 1'b0);
        send_item(16'h0005, 1'b0);
        send_item(16'h0007, 1'b0);

        // Pattern swapped while two elements are still held.
        send_item(16'h0005, 1'b0);
        send_item(16'h0005, 1'b0);
        set_replacer({32'h0, 16'h0009, 16'h0005}, 3'd2, {$urandom, $urandom}, 3'd1);
        write_reg(CFG_INDEX_UNUSED, {$urandom, $urandom});
        send_item(16'h0009, 1'b1);

        // Length zero acts as one; a deleted final element yields nothing at all.
        set_replacer({16'h0000, $urandom, 16'h0003}, 3'd0, {$urandom, $urandom}, 3'd0);
        send_item(16'h0003, 1'b1);
    endtask

    task automatic test_backpressure();
        int k;
        new_random_setting();
        tx_idle_pct = 0;
        @(negedge i_clk);
        hold_requests++;
        for (k = 0; k < 24; k++) send_item(pick_elem(), k == 23);
        tx_idle_pct = 32;
    endtask

    task automatic test_random_streams();
        int phase, budget, r, k, plen, cut;
        for (phase = 0; phase < PHASES; phase++) begin
            new_random_setting();
            tx_idle_pct = (phase == 3 || phase == 4) ? 0 : 32;
            rx_idle_pct = tx_idle_pct;
            budget = PHASE_ITEMS;
            while (budget > 0) begin
                r    = $urandom_range(99);
                plen = eff_pat_len();
                if (r < 35) begin
                    for (k = 0; k < plen; k++)
                        send_item(pat_slot(model_pat_words, k),
                                  k == plen - 1 && $urandom_range(15) == 0);
                    budget -= plen;
                end else if (r < 55 && plen > 1) begin
                    cut = $urandom_range(1, plen - 1);
                    for (k = 0; k < cut; k++)
                        send_item(pat_slot(model_pat_words, k), 1'b0);
                    send_item(pick_elem(), $urandom_range(15) == 0);
                    budget -= cut + 1;
                end else begin
                    send_item(pick_elem(), $urandom_range(15) == 0);
                    budget--;
                end
            end
        end
        tx_idle_pct = 32;
        rx_idle_pct = 32;
    endtask

    initial begin
        int hold_served, hold_left;
        hold_served   = 0;
        hold_left     = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                m_axis_tready = 1'b0;
                hold_left--;
            end else begin
                m_axis_tready = ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_beat want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (expected_out.size() == 0) begin
                $error("unexpected output transaction: out_element=%0d",
                       $signed(m_axis_tdata[EW-1:0]));
                errors++;
            end else begin
                want = expected_out.pop_front();
                if (m_axis_tdata[EW-1:0] !== want.elem) begin
                    $error("out_element: expected %0d, got %0d",
                           $signed(want.elem), $signed(m_axis_tdata[EW-1:0]));
                    errors++;
                end
                if (m_axis_tlast !== want.run_last) begin
                    $error("run_last: expected %0b, got %0b", want.run_last, m_axis_tlast);
                    errors++;
                end
                if (m_axis_tuser !== want.stream_done) begin
                    $error("stream_done: expected %0b, got %0b", want.stream_done, m_axis_tuser);
                    errors++;
                end
            end
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = srep_pkg::CFG_PATTERN_WORDS;
        i_cfg_data    = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults();
        test_directed_cases();
        test_backpressure();
        test_random_streams();

        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (expected_out.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        $display("Run covered %0d stream elements, %0d output transactions, %0d replacements.",
                 items_sent, results_seen, replacements);
        $display("It used %0d register writes, saturated and zero lengths and a %0d-cycle hold.",
                 reg_writes, HOLD_CYCLES);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
